// ===== rtl/html_entity_decoder_macros.svh =====
// assertion macros shared by the decoder
`ifndef HTML_ENTITY_DECODER_MACROS_SVH
`define HTML_ENTITY_DECODER_MACROS_SVH

// cond must never hold outside reset
`define HED_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("decoder check failed");

// a in a cycle implies b in the same cycle
`define HED_ASSERT_IMPL(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("decoder check failed");

// a in a cycle implies b in the next cycle
`define HED_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("decoder check failed");

`endif

// ===== rtl/hed_pkg.sv =====
`default_nettype none
package hed_pkg;

	localparam int HED_WINDOW = 12;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;
	localparam int NUM_NAMES = 6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_is_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_is_last;
	} out_word_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_OPEN,
		OP_PASS,
		OP_SEMI_OK,
		OP_FAIL_SEMI,
		OP_ADD,
		OP_ADD_FAIL,
		OP_FAIL_END,
		OP_FLUSH,
		OP_UTF
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic r_empty;
		logic open;
		logic last;
		logic go;
		logic is_amp;
		logic is_semi;
		logic resolve_ok;
		logic full_next;
		logic utf_last;
		logic hold_v;
	} status_t;

	typedef enum logic [2:0] {
		NM_AMP  = 3'd0,
		NM_QUOT = 3'd1,
		NM_APOS = 3'd2,
		NM_LT   = 3'd3,
		NM_GT   = 3'd4,
		NM_NBSP = 3'd5
	} name_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [2:0] name_len(input name_t n);
		logic [2:0] l;
		unique case (n)
			NM_AMP:  l = 3'd3;
			NM_QUOT: l = 3'd4;
			NM_APOS: l = 3'd4;
			NM_LT:   l = 3'd2;
			NM_GT:   l = 3'd2;
			NM_NBSP: l = 3'd4;
			default: l = 3'd0;
		endcase
		return l;
	endfunction

	function automatic logic [31:0] name_chars(input name_t n);
		logic [31:0] s;
		unique case (n)
			NM_AMP:  s = {8'h00, "pma"};
			NM_QUOT: s = "touq";
			NM_APOS: s = "sopa";
			NM_LT:   s = {16'h0000, "tl"};
			NM_GT:   s = {16'h0000, "tg"};
			NM_NBSP: s = "psbn";
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] name_value(input name_t n);
		logic [7:0] v;
		unique case (n)
			NM_AMP:  v = 8'h26;
			NM_QUOT: v = 8'h22;
			NM_APOS: v = 8'h27;
			NM_LT:   v = 8'h3C;
			NM_GT:   v = 8'h3E;
			NM_NBSP: v = 8'h20;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] code, input logic [2:0] len,
			input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h80 | {2'b00, code[5:0]};
		case (len)
			3'd1: b = code[7:0];
			3'd2: begin
				if (idx == 2'd0) b = 8'hC0 | {3'b000, code[10:6]};
			end
			3'd3: begin
				if (idx == 2'd0) b = 8'hE0 | {4'h0, code[15:12]};
				else if (idx == 2'd1) b = 8'h80 | {2'b00, code[11:6]};
			end
			default: begin
				if (idx == 2'd0) b = 8'hF0 | {5'b00000, code[20:18]};
				else if (idx == 2'd1) b = 8'h80 | {2'b00, code[17:12]};
				else if (idx == 2'd2) b = 8'h80 | {2'b00, code[11:6]};
			end
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hed_ctrl.sv =====
`default_nettype none
module hed_ctrl import hed_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t st,
	output cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_UTF  = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (st.go) begin
					if (!st.r_empty) begin
						if (!st.open) begin
							cmd.op = st.is_amp ? OP_OPEN : OP_PASS;
						end else if (st.is_semi) begin
							if (st.resolve_ok) begin
								cmd.op  = OP_SEMI_OK;
								state_d = ST_UTF;
							end else begin
								cmd.op = OP_FAIL_SEMI;
							end
						end else begin
							cmd.op = st.full_next ? OP_ADD_FAIL : OP_ADD;
						end
					end else if (st.last && st.open) begin
						cmd.op = OP_FAIL_END;
					end else begin
						cmd.op  = OP_FLUSH;
						state_d = ST_IDLE;
					end
				end
			end
			ST_UTF: begin
				if (st.go) begin
					cmd.op = OP_UTF;
					if (st.utf_last) state_d = ST_RUN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== rtl/hed_dp.sv =====
`default_nettype none
module hed_dp import hed_pkg::*; #(
	parameter int WINDOW = HED_WINDOW
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cmd_t     cmd,
	output status_t       st,
	input  wire in_word_t in_word,
	input  wire logic     out_ready,
	output logic          out_valid,
	output out_word_t     out_word
);

	localparam int CW = $clog2(WINDOW + 1);
	localparam int IW = $clog2(WINDOW);

	// held bytes sit at 0..pcnt-1, bytes waiting to be fed follow them
	logic [7:0]    buf_q [WINDOW];
	logic [7:0]    buf_sh [WINDOW];
	logic [CW-1:0] pcnt_q, rcnt_q;
	logic          open_q, last_q;

	logic [NUM_NAMES-1:0] flag_q, flag_d;
	logic          num_q, hex_q, bad_q;
	logic [31:0]   cp_q;

	logic [20:0]   code_q;
	logic [2:0]    ulen_q;
	logic [1:0]    uidx_q;

	logic [7:0]    hold_q;
	logic          hold_v_q, out_v_q;
	out_word_t     out_q;

	logic [7:0]    cur;
	logic [7:0]    emit_byte;
	logic          emit;
	logic          push;
	logic          go;
	logic          named_ok, num_ok;
	logic [7:0]    named_val;
	logic [20:0]   code_d;
	logic [2:0]    ulen_d;
	logic [CW-1:0] sh;
	logic [4:0]    hd;
	logic [7:0]    lc;
	logic [31:0]   dec_next;
	logic [31:0]   nm_chars;

	assign cur = buf_q[pcnt_q[IW-1:0]];
	assign go  = !out_v_q || out_ready;
	assign lc  = to_lower(cur);
	assign hd  = hex_digit(cur);
	assign dec_next = (cp_q << 3) + (cp_q << 1) + {28'd0, cur[3:0]};

	always_comb begin
		nm_chars = '0;
		for (int n = 0; n < NUM_NAMES; n++) begin
			nm_chars  = name_chars(name_t'(n));
			flag_d[n] = (pcnt_q == '0 || flag_q[n])
				&& (pcnt_q < CW'(name_len(name_t'(n))))
				&& (lc == nm_chars[8*pcnt_q[1:0] +: 8]);
		end
	end

	always_comb begin
		named_ok  = 1'b0;
		named_val = 8'h00;
		for (int n = NUM_NAMES - 1; n >= 0; n--) begin
			if (flag_q[n] && pcnt_q == CW'(name_len(name_t'(n)))) begin
				named_ok  = 1'b1;
				named_val = name_value(name_t'(n));
			end
		end
	end

	assign num_ok = (pcnt_q != '0) && num_q && !bad_q && (cp_q != 32'd0) && (cp_q <= CP_MAX);
	assign code_d = named_ok ? {13'd0, named_val} : cp_q[20:0];

	always_comb begin
		if (code_d < 21'h80) ulen_d = 3'd1;
		else if (code_d < 21'h800) ulen_d = 3'd2;
		else if (code_d < 21'h10000) ulen_d = 3'd3;
		else ulen_d = 3'd4;
	end

	assign sh = (cmd.op == OP_SEMI_OK) ? pcnt_q + CW'(1) : CW'(1);

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			if (i + int'(sh) < WINDOW) buf_sh[i] = buf_q[IW'(i + int'(sh))];
			else buf_sh[i] = buf_q[i];
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_byte = CH_AMP;
		case (cmd.op)
			OP_PASS: begin
				emit      = 1'b1;
				emit_byte = cur;
			end
			OP_FAIL_SEMI, OP_ADD_FAIL, OP_FAIL_END: emit = 1'b1;
			OP_UTF: begin
				emit      = 1'b1;
				emit_byte = utf8_byte(code_q, ulen_q, uidx_q);
			end
			default: emit = 1'b0;
		endcase
	end

	assign push = hold_v_q && (emit || cmd.op == OP_FLUSH);

	always_comb begin
		st.r_empty    = (rcnt_q == '0);
		st.open       = open_q;
		st.last       = last_q;
		st.go         = go;
		st.is_amp     = (cur == CH_AMP);
		st.is_semi    = (cur == CH_SEMI);
		st.resolve_ok = named_ok || num_ok;
		st.full_next  = (pcnt_q + CW'(1) == CW'(WINDOW));
		st.utf_last   = ({1'b0, uidx_q} + 3'd1 == ulen_q);
		st.hold_v     = hold_v_q;
	end

	// counts and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			rcnt_q <= '0;
			open_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					rcnt_q <= CW'(1);
					last_q <= in_word.in_is_last;
				end
				OP_OPEN: begin
					rcnt_q <= rcnt_q - CW'(1);
					open_q <= 1'b1;
				end
				OP_PASS: rcnt_q <= rcnt_q - CW'(1);
				OP_SEMI_OK: begin
					rcnt_q <= rcnt_q - CW'(1);
					pcnt_q <= '0;
					open_q <= 1'b0;
				end
				OP_ADD: begin
					pcnt_q <= pcnt_q + CW'(1);
					rcnt_q <= rcnt_q - CW'(1);
				end
				OP_FAIL_SEMI, OP_ADD_FAIL: begin
					rcnt_q <= rcnt_q + pcnt_q;
					pcnt_q <= '0;
					open_q <= 1'b0;
				end
				OP_FAIL_END: begin
					rcnt_q <= pcnt_q;
					pcnt_q <= '0;
					open_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// byte buffer, matcher and code point
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: buf_q[pcnt_q[IW-1:0]] <= in_word.in_byte;
			OP_OPEN, OP_PASS, OP_SEMI_OK: buf_q <= buf_sh;
			default: ;
		endcase
		if (cmd.op == OP_ADD) begin
			flag_q <= flag_d;
			if (pcnt_q == '0) begin
				num_q <= (cur == CH_HASH);
				hex_q <= 1'b0;
				bad_q <= 1'b0;
				cp_q  <= 32'd0;
			end else if (pcnt_q == CW'(1) && (cur == CH_X_LO || cur == CH_X_UP)) begin
				hex_q <= 1'b1;
			end else if (hex_q) begin
				if (hd[4]) cp_q <= {cp_q[27:0], hd[3:0]};
				else bad_q <= 1'b1;
			end else begin
				if (cur >= 8'h30 && cur <= 8'h39) cp_q <= dec_next;
				else bad_q <= 1'b1;
			end
		end
		if (cmd.op == OP_SEMI_OK) begin
			code_q <= code_d;
			ulen_q <= ulen_d;
			uidx_q <= 2'd0;
		end else if (cmd.op == OP_UTF) begin
			uidx_q <= uidx_q + 2'd1;
		end
	end

	// one held word of lookahead marks the last word of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			out_v_q <= push || (out_v_q && !out_ready);
			if (emit) begin
				hold_v_q <= 1'b1;
			end
			if (cmd.op == OP_FLUSH) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hold_q <= emit_byte;
			if (hold_v_q) out_q <= '{out_byte: hold_q, out_is_last: 1'b0};
		end
		if (cmd.op == OP_FLUSH && hold_v_q) begin
			out_q <= '{out_byte: hold_q, out_is_last: last_q};
		end
	end

	assign out_valid = out_v_q;
	assign out_word  = out_q;

endmodule
`default_nettype wire

// ===== rtl/html_entity_decoder.sv =====
// html entity decoder
// in channel: in_valid/in_ready carry one text byte per word plus a last-of-stream
// mark. out channel: out_valid/out_ready carry decoded bytes; out_is_last is set on
// the final byte of a stream.
// one input word is taken at a time. the sequencer loads it, then feeds each byte
// through the entity scanner (the new byte, plus any held bytes replayed after a
// failed reference), emits each utf-8 byte of a resolved reference and closes the
// word.
// reset empties the held-byte buffer and the output register; no clearing pass.
// when the receiver stalls, the output register holds its word and the sequencer
// waits; no word is dropped. in_ready stays low until the current word is done.
`default_nettype none
`include "html_entity_decoder_macros.svh"
module html_entity_decoder import hed_pkg::*; #(
	parameter int WINDOW = HED_WINDOW
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_word_t in_word,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_word_t     out_word
);

	cmd_t    cmd;
	status_t st;

	hed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	hed_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_word   (in_word),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	`HED_ASSERT_IMPL(a_idle_hold_empty, in_ready, !st.hold_v && st.r_empty)
	`HED_ASSERT_IMPL(a_work_needs_slot, cmd.op != OP_NONE && cmd.op != OP_LOAD, st.go)
	`HED_ASSERT_NEXT(a_busy_after_load, in_valid && in_ready, !in_ready)

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

class decode_scoreboard;
	logic [7:0] held[hed_pkg::HED_WINDOW];
	int unsigned held_cnt;
	bit amp_open;
	hed_pkg::out_word_t expected_words[$];
	hed_pkg::out_word_t step_words[$];
	int errors;

	function new();
		held_cnt = 0;
		amp_open = 0;
		errors = 0;
	endfunction

	function logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function bit name_eq(int unsigned len, string w);
		if (len != w.len()) return 0;
		for (int i = 0; i < len; i++)
			if (lower(held[i]) != w[i]) return 0;
		return 1;
	endfunction

	function void put(logic [7:0] b);
		hed_pkg::out_word_t w;
		w.out_byte = b;
		w.out_is_last = 1'b0;
		step_words.push_back(w);
	endfunction

	function bit resolve_ref();
		int unsigned len;
		logic [31:0] cp;
		logic [7:0] c;
		len = held_cnt > 0 ? held_cnt - 1 : 0;
		cp = 0;
		if (name_eq(len, "amp")) begin put("&"); return 1; end
		if (name_eq(len, "quot")) begin put("\""); return 1; end
		if (name_eq(len, "apos") || name_eq(len, "#39")) begin put("'"); return 1; end
		if (name_eq(len, "lt")) begin put("<"); return 1; end
		if (name_eq(len, "gt")) begin put(">"); return 1; end
		if (name_eq(len, "nbsp")) begin put(" "); return 1; end
		if (len == 0 || held[0] != hed_pkg::CH_HASH) return 0;
		if (len >= 2 && (held[1] == hed_pkg::CH_X_LO || held[1] == hed_pkg::CH_X_UP)) begin
			for (int i = 2; i < len; i++) begin
				c = held[i];
				if (c >= "0" && c <= "9") cp = (cp << 4) | (c - "0");
				else if (c >= "a" && c <= "f") cp = (cp << 4) | (c - "a" + 10);
				else if (c >= "A" && c <= "F") cp = (cp << 4) | (c - "A" + 10);
				else return 0;
			end
		end else begin
			for (int i = 1; i < len; i++) begin
				c = held[i];
				if (c < "0" || c > "9") return 0;
				cp = cp * 10 + (c - "0");
			end
		end
		if (cp == 0 || cp > hed_pkg::CP_MAX) return 0;
		if (cp < 'h80) put(cp[7:0]);
		else if (cp < 'h800) begin
			put(8'hC0 | cp[10:6]);
			put(8'h80 | cp[5:0]);
		end else if (cp < 'h10000) begin
			put(8'hE0 | cp[15:12]);
			put(8'h80 | cp[11:6]);
			put(8'h80 | cp[5:0]);
		end else begin
			put(8'hF0 | cp[20:18]);
			put(8'h80 | cp[17:12]);
			put(8'h80 | cp[11:6]);
			put(8'h80 | cp[5:0]);
		end
		return 1;
	endfunction

	// literal ampersand, then the held bytes go through again
	function void reject_ref();
		logic [7:0] copy[hed_pkg::HED_WINDOW];
		int unsigned n;
		n = held_cnt;
		copy = held;
		amp_open = 0;
		held_cnt = 0;
		put(hed_pkg::CH_AMP);
		for (int i = 0; i < n; i++) scan(copy[i]);
	endfunction

	function void scan(logic [7:0] b);
		if (!amp_open) begin
			if (b == hed_pkg::CH_AMP) begin
				amp_open = 1;
				held_cnt = 0;
			end else put(b);
			return;
		end
		if (held_cnt < hed_pkg::HED_WINDOW) begin
			held[held_cnt] = b;
			held_cnt++;
		end
		if (b == hed_pkg::CH_SEMI) begin
			if (resolve_ref()) begin
				amp_open = 0;
				held_cnt = 0;
			end else reject_ref();
			return;
		end
		if (held_cnt >= hed_pkg::HED_WINDOW) reject_ref();
	endfunction

	function void note_input(hed_pkg::in_word_t w);
		step_words.delete();
		scan(w.in_byte);
		if (w.in_is_last) while (amp_open) reject_ref();
		if (w.in_is_last && step_words.size() > 0)
			step_words[step_words.size() - 1].out_is_last = 1'b1;
		foreach (step_words[i]) expected_words.push_back(step_words[i]);
	endfunction

	function void check_output(hed_pkg::out_word_t w);
		hed_pkg::out_word_t e;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected word, expected none, actual %h/%b",
				$time, w.out_byte, w.out_is_last);
			errors++;
			return;
		end
		e = expected_words.pop_front();
		if (w.out_byte !== e.out_byte) begin
			$display("%0t: out_byte expected %h actual %h", $time, e.out_byte, w.out_byte);
			errors++;
		end
		if (w.out_is_last !== e.out_is_last) begin
			$display("%0t: out_is_last expected %b actual %b", $time, e.out_is_last,
				w.out_is_last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import hed_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;

	decode_scoreboard sb;
	bit stim_done;
	int burst_left;

	html_entity_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(in_word);
		if (arst_n && out_valid && out_ready) sb.check_output(out_word);
	end

	// receiver drops ready at random, drawn anew each cycle
	initial begin
		int mode;
		out_ready = 0;
		forever begin
			@(negedge clk);
			mode = $urandom_range(0, 99);
			if (mode < 5) out_ready <= 0;
			else if (mode < 40) out_ready <= ($urandom_range(0, 3) != 0);
			else out_ready <= 1;
		end
	end

	// valid stays up between words of a burst and drops only for a gap
	task automatic send_word(logic [7:0] b, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1;
		in_word <= '{in_byte: b, in_is_last: last};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_text(string s, logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], last_at_end && i == s.len() - 1);
	endtask

	function automatic logic [7:0] text_char();
		string pool;
		pool = "&;#xX0123456789aAfFgGlLtTmMpPqQoOuUsSnNbB9z ";
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	initial begin
		string refs[$];
		string s;
		int n;
		sb = new();
		arst_n = 0;
		in_valid = 0;
		in_word = '0;
		burst_left = 0;
		stim_done = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_text("a&amp;&QUOT;&apos;&#39;&lt;&Gt;&nbsp;", 0);
		send_text("&#65;&#xe9;&#X20AC;&#x1F600;&#xD800;", 0);
		send_text("&#0;&#x;&bogus;&#1114112;&#4294967361;", 0);
		send_text("&abcdefghijklm", 0);
		send_word(8'h00, 0);
		send_word(8'hFF, 0);
		send_text("&#12", 1);
		send_word(8'h80, 1);
		refs = '{"&amp;", "&lt;", "&gT;", "&quot;", "&APOS;", "&#39;", "&nbsp;",
			"&#128;", "&#x7f;", "&#x10ffff;", "&#x110000;", "&#;", "&q;", "&#1a;"};
		n = 0;
		while (n < 320) begin
			case ($urandom_range(0, 9))
				0, 1, 2: s = refs[$urandom_range(0, refs.size() - 1)];
				3, 4: begin
					s = $sformatf("&#%0d;", $urandom_range(0, 'h11FFFF));
				end
				5: s = $sformatf("&#x%0h;", $urandom());
				6: begin
					s = "&";
					repeat ($urandom_range(0, 14)) s = {s, string'(text_char())};
				end
				default: begin
					s = "";
					repeat ($urandom_range(1, 4)) s = {s, string'(8'($urandom()))};
				end
			endcase
			for (int i = 0; i < s.len(); i++) begin
				send_word(s[i], $urandom_range(0, 29) == 0);
				n++;
			end
		end
		send_word(8'($urandom()), 1);
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

`default_nettype wire
